[hw/rtl/ledbt_pkg.sv]
// package for the two channel led blink timer
// holds command codes, per channel state type and reset values; no dependencies
package ledbt_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [15:0] DEFAULT_HALF  = 16'd500;
    localparam logic [31:0] DEFAULT_TOTAL = 32'd1000;

    typedef struct packed {
        logic        active;
        logic        lamp;
        logic [15:0] half_len;
        logic [31:0] total_len;
        logic [16:0] phase_count;
        logic [31:0] elapsed;
    } chan_state_t;

    localparam chan_state_t CHAN_RESET = '{
        active:      1'b0,
        lamp:        1'b0,
        half_len:    DEFAULT_HALF,
        total_len:   DEFAULT_TOTAL,
        phase_count: 17'd0,
        elapsed:     32'd0
    };

endpackage

[hw/rtl/two_channel_led_blink_timer.sv]
// two channel led blink timer top level
// one request register, per channel counter update logic and a result register
// depends on ledbt_pkg
//
// Usage: each request on the in channel (cmd, channel, half_period, duration)
// is a one millisecond tick for all channels, a start or a clear of one channel.
// Every request gives exactly one result on the out channel holding the lamp
// and active bits of channels 0 and 1 after that request.
// A request is taken at a rising edge with in_valid high and in_stall low; a
// result is taken with out_valid high and out_stall low.
// A taken request passes the request register, the state update and the result register, in that order.
// Throughput: one request per cycle while out_stall is low, set by the combinational
// state update between the request register and the result register.
// When out_stall holds a waiting result, one more request is taken into the
// request register; in_stall then rises until the result moves on.
// Reset (rst_n low, asynchronous) idles every channel with lamp off, half
// period 500 and duration 1000, and empties both registers.
module two_channel_led_blink_timer
    import ledbt_pkg::*;
#(
    parameter int NUM_CHANNELS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic        channel,
    input  logic [15:0] half_period,
    input  logic [31:0] duration,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  lamp_bits,
    output logic [1:0]  active_bits
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_cmd_reg;
    logic        s1_channel_reg;
    logic [15:0] s1_half_reg;
    logic [31:0] s1_duration_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  lamp_bits_reg;
    logic [1:0]  active_bits_reg;
    logic [1:0]  lamp_bits_next;
    logic [1:0]  active_bits_next;

    chan_state_t state_reg  [NUM_CHANNELS];
    chan_state_t state_next [NUM_CHANNELS];

    logic out_free;
    logic process;
    logic accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign process  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept ? 1'b1 : (process ? 1'b0 : s1_valid_reg);
    assign out_valid_next = process ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= cmd;
            s1_channel_reg  <= channel;
            s1_half_reg     <= half_period;
            s1_duration_reg <= duration;
        end
    end

    // per channel update
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chan
        logic        sel;
        logic [31:0] inc_elapsed;
        logic [16:0] inc_phase;
        logic        short_dur;

        if (c < 2)
        begin : g_addr
            assign sel = (s1_channel_reg == 1'(c));
        end
        else
        begin : g_noaddr
            assign sel = 1'b0;
        end

        assign inc_elapsed = state_reg[c].elapsed + 32'd1;
        assign inc_phase   = state_reg[c].phase_count + 17'd1;
        assign short_dur   = (s1_duration_reg != 32'd0)
                             && (s1_duration_reg < {16'd0, s1_half_reg});

        always_comb
        begin
            state_next[c] = state_reg[c];
            case (s1_cmd_reg)
                CMD_TICK:
                begin
                    if (state_reg[c].active)
                    begin
                        if ((state_reg[c].total_len != 32'd0)
                            && (inc_elapsed >= state_reg[c].total_len))
                        begin
                            state_next[c].active      = 1'b0;
                            state_next[c].lamp        = 1'b0;
                            state_next[c].phase_count = 17'd0;
                            state_next[c].elapsed     = 32'd0;
                        end
                        else
                        begin
                            if (state_reg[c].total_len != 32'd0)
                            begin
                                state_next[c].elapsed = inc_elapsed;
                            end
                            if (state_reg[c].half_len != 16'd0)
                            begin
                                if (inc_phase > {1'b0, state_reg[c].half_len})
                                begin
                                    state_next[c].lamp        = !state_reg[c].lamp;
                                    state_next[c].phase_count = 17'd0;
                                end
                                else
                                begin
                                    state_next[c].phase_count = inc_phase;
                                end
                            end
                        end
                    end
                end
                CMD_START:
                begin
                    if (sel && !state_reg[c].active)
                    begin
                        state_next[c].half_len  = s1_half_reg;
                        state_next[c].total_len = short_dur
                                                  ? {15'd0, s1_half_reg, 1'b0}
                                                  : s1_duration_reg;
                        state_next[c].lamp      = 1'b1;
                        state_next[c].active    = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    if (sel)
                    begin
                        state_next[c] = CHAN_RESET;
                    end
                end
                default:
                begin
                    state_next[c] = state_reg[c];
                end
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                state_reg[c] <= CHAN_RESET;
            end
            else if (process)
            begin
                state_reg[c] <= state_next[c];
            end
        end
    end

    // result bits for channels 0 and 1
    for (genvar b = 0; b < 2; b++)
    begin : g_bits
        if (b < NUM_CHANNELS)
        begin : g_used
            assign lamp_bits_next[b]   = state_next[b].lamp;
            assign active_bits_next[b] = state_next[b].active;
        end
        else
        begin : g_unused
            assign lamp_bits_next[b]   = 1'b0;
            assign active_bits_next[b] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            lamp_bits_reg   <= lamp_bits_next;
            active_bits_reg <= active_bits_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lamp_bits   = lamp_bits_reg;
    assign active_bits = active_bits_reg;

`ifndef SYNTHESIS
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chk
        // an idle channel has its lamp off and its counters at rest
        a_idle_rest: assert property (@(posedge clk) disable iff (!rst_n)
            !state_reg[c].active |-> (!state_reg[c].lamp
                && (state_reg[c].elapsed == 32'd0)
                && (state_reg[c].phase_count == 17'd0)))
            else $error("idle channel not at rest");

        // a finite run never reaches its duration while still active
        a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
            (state_reg[c].active && (state_reg[c].total_len != 32'd0))
                |-> (state_reg[c].elapsed < state_reg[c].total_len))
            else $error("elapsed count reached duration while active");

        // phase counter never passes the half period
        a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
            state_reg[c].phase_count <= {1'b0, state_reg[c].half_len})
            else $error("phase counter beyond half period");
    end

    // channel 0 state only moves when a request is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(process) |-> $stable(state_reg[0]))
        else $error("channel state changed without a request");
`endif

endmodule
